### hdl/rdiv_pkg.sv
`default_nettype none

package rdiv_pkg;

    localparam int W         = 8;
    localparam int IDX_W     = $clog2(W);
    localparam int STEPS_DEF = 2;

    typedef logic [W-1:0]     t_byte;
    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        t_byte part;   // partial remainder (magnitude domain), final remainder at the end
        t_byte dmag;   // divisor magnitude
        t_byte quo;    // quotient bits built so far, final quotient at the end
        logic  neg;    // operand signs differ
    } t_stage;

    // Take magnitudes and sign rule of one operand pair.
    function automatic t_stage stage_in(logic func, t_byte a, t_byte b);
        t_stage st;
        logic   neg_a;
        logic   neg_b;
        neg_a   = func & a[W-1];
        neg_b   = func & b[W-1];
        st.part = neg_a ? t_byte'(-a) : a;
        st.dmag = neg_b ? t_byte'(-b) : b;
        st.quo  = '0;
        st.neg  = neg_a ^ neg_b;
        return st;
    endfunction

    // n restoring steps, from quotient bit top downward.
    // part >= dmag << s is tested as (part >> s) >= dmag, which stays 8 bits wide.
    function automatic t_stage core_steps(t_stage st_i, t_idx top, int n);
        t_stage st;
        t_idx   s;
        t_byte  shr;
        st = st_i;
        for (int j = 0; j < W; j++) begin
            if (j < n) begin
                s   = t_idx'(top - t_idx'(j));
                shr = st.part >> s;
                if (shr >= st.dmag) begin
                    st.quo[s] = 1'b1;
                    st.part   = t_byte'(st.part - t_byte'(st.dmag << s));
                end
            end
        end
        return st;
    endfunction

    // Negate quotient and remainder together when the signs differ.
    function automatic t_stage stage_out(t_stage st_i);
        t_stage st;
        st = st_i;
        if (st_i.neg) begin
            st.quo  = t_byte'(-st_i.quo);
            st.part = t_byte'(-st_i.part);
        end
        return st;
    endfunction

endpackage

`default_nettype wire

### hdl/restoring_divider_8bit.sv
`default_nettype none

// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     i_func, i_dividend, i_divisor
// out       output     o_out_valid / i_out_ready   o_quotient, o_remainder
//
// One beat per cycle in and out while the output is not stalled. The stages are
// an operand stage, one stage per P_STEPS restoring steps, and a sign/output stage.
// Each stage holds a valid bit; a stage loads when it is empty or its successor
// moves, so bubbles collapse and a stalled output holds without loss.
// Synchronous active-low reset clears the valid bits only.

module restoring_divider_8bit #(
    parameter int P_STEPS = rdiv_pkg::STEPS_DEF   // 1, 2, 4 or 8
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  wire             i_func,
    input  wire  [7:0]      i_dividend,
    input  wire  [7:0]      i_divisor,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output logic [7:0]      o_quotient,
    output logic [7:0]      o_remainder
);

    localparam int NC = rdiv_pkg::W / P_STEPS;   // core stages
    localparam int NS = NC + 2;                  // all stages

    logic                r_v   [NS];
    rdiv_pkg::t_stage    r_st  [NS];
    rdiv_pkg::t_stage    n_st  [NS];
    logic                w_adv [NS];

    // backward advance chain
    assign w_adv[NS-1] = !r_v[NS-1] || i_out_ready;

    genvar k;
    generate
        for (k = 0; k < NS - 1; k++) begin : g_adv
            assign w_adv[k] = !r_v[k] || w_adv[k+1];
        end

        assign n_st[0] = rdiv_pkg::stage_in(i_func, i_dividend, i_divisor);

        for (k = 1; k <= NC; k++) begin : g_core
            localparam int LP_TOP = rdiv_pkg::W - 1 - (k - 1) * P_STEPS;
            assign n_st[k] = rdiv_pkg::core_steps(r_st[k-1],
                                                  rdiv_pkg::t_idx'(LP_TOP), P_STEPS);
        end

        assign n_st[NS-1] = rdiv_pkg::stage_out(r_st[NS-2]);
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) begin
                r_v[i] <= 1'b0;
            end
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (w_adv[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NS; i++) begin
            if (w_adv[i]) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    assign o_in_ready  = w_adv[0];
    assign o_out_valid = r_v[NS-1];
    assign o_quotient  = r_st[NS-1].quo;
    assign o_remainder = r_st[NS-1].part;

    // an empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NS-1] |-> o_in_ready)
        else $error("input stalled with empty output stage");

    // after the last step the remainder is below a nonzero divisor
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NC] && (r_st[NC].dmag != '0) |-> r_st[NC].part < r_st[NC].dmag)
        else $error("core remainder not below divisor");

    // zero divisor sets every quotient bit in the core
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NC] && (r_st[NC].dmag == '0) |-> r_st[NC].quo == '1)
        else $error("zero divisor quotient not all ones");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire
